/* hdl/trp_pkg.sv */
// Package for the trie root prefix replacer.
// Holds table sizes, character codes, word modes and controller/datapath links.
// No dependencies.
package trp_pkg;

    localparam int NODES        = 1024;
    localparam int ALPHABET     = 26;
    localparam int NODE_W       = $clog2(NODES);
    localparam int FREE_W       = $clog2(NODES + 1);
    localparam int SLOT_W       = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int ENTRIES      = NODES * ALPHABET;
    localparam int CADDR_W      = $clog2(ENTRIES);

    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] FIRST_LETTER = 8'h61;

    localparam logic [1:0] MODE_MATCH = 2'd0;
    localparam logic [1:0] MODE_DROP  = 2'd1;
    localparam logic [1:0] MODE_COPY  = 2'd2;

    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic stall;
    } status_t;

endpackage

/* hdl/trp_ctrl.sv */
// Controller for the trie root prefix replacer.
// Sequences the clearing pass, request accept and execute steps.
// Depends on trp_pkg.
module trp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  trp_pkg::status_t sts,
    output trp_pkg::cmd_t   cmd
);
    import trp_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!sts.stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready  = ready_reg;
    assign cmd.clear = (state_reg == ST_CLEAR);
    assign cmd.load  = ready_reg && in_valid;
    assign cmd.exec  = (state_reg == ST_EXEC);

endmodule

/* hdl/trp_dp.sv */
// Datapath for the trie root prefix replacer.
// Holds the child table and root end memories, cursors, word mode and result register.
// Depends on trp_pkg.
module trp_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  trp_pkg::cmd_t    cmd,
    output trp_pkg::status_t sts,
    input  logic             func,
    input  logic [7:0]       symbol,
    input  logic             last_symbol,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_symbol,
    output logic             kept,
    output logic             sentence_end,
    output logic             table_full
);
    import trp_pkg::*;

    logic [NODE_W-1:0]  child_mem [ENTRIES];
    logic               mark_mem  [NODES];

    logic [CADDR_W-1:0] clear_cnt_reg;
    logic               func_reg;
    logic [7:0]         sym_reg;
    logic               last_reg;
    logic               slot_ok_reg;
    logic [CADDR_W-1:0] caddr_reg;
    logic [NODE_W-1:0]  child_rd_reg;
    logic               mark_rd_reg;

    logic [NODE_W-1:0]  ins_cur_reg;
    logic [NODE_W-1:0]  ins_cur_next;
    logic [NODE_W-1:0]  match_cur_reg;
    logic [NODE_W-1:0]  match_cur_next;
    logic [1:0]         mode_reg;
    logic [1:0]         mode_next;
    logic [FREE_W-1:0]  free_reg;
    logic [FREE_W-1:0]  free_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               dead_reg;
    logic               dead_next;

    logic               out_valid_reg;
    logic [7:0]         out_sym_reg;
    logic               kept_reg;
    logic               kept_next;
    logic               end_reg;
    logic               full_reg;

    logic [7:0]         in_off;
    logic               in_slot_ok;
    logic [SLOT_W-1:0]  in_slot;
    logic [NODE_W-1:0]  rd_node;
    logic [CADDR_W-1:0] rd_addr;

    logic               has_result;
    logic               commit;
    logic               dead_now;
    logic               alloc;
    logic               no_room;
    logic [NODE_W-1:0]  new_cur;
    logic               child_we;
    logic               mark_we;

    assign in_off     = symbol - FIRST_LETTER;
    assign in_slot_ok = (symbol >= FIRST_LETTER) && (in_off < 8'(ALPHABET));
    assign in_slot    = in_slot_ok ? in_off[SLOT_W-1:0] : '0;
    assign rd_node    = func ? match_cur_reg : ins_cur_reg;
    assign rd_addr    = CADDR_W'(CADDR_W'(rd_node) * CADDR_W'(ALPHABET))
                        + CADDR_W'(in_slot);

    assign has_result = func_reg;
    assign sts.stall  = cmd.exec && has_result && out_valid_reg && !out_ready;
    assign commit     = cmd.exec && !sts.stall;
    assign sts.clear_done = (clear_cnt_reg == CADDR_W'(ENTRIES - 1));

    assign dead_now = dead_reg || !slot_ok_reg;
    assign alloc    = !ovf_reg && !dead_now && (child_rd_reg == '0);
    assign no_room  = alloc && (free_reg >= FREE_W'(NODES));
    assign new_cur  = (child_rd_reg == '0) ? free_reg[NODE_W-1:0] : child_rd_reg;
    assign child_we = commit && !func_reg && alloc && !no_room;
    assign mark_we  = commit && !func_reg && !ovf_reg && !no_room && last_reg
                      && !dead_now;

    always_comb
    begin
        ins_cur_next   = ins_cur_reg;
        match_cur_next = match_cur_reg;
        mode_next      = mode_reg;
        free_next      = free_reg;
        ovf_next       = ovf_reg;
        dead_next      = dead_reg;
        kept_next      = 1'b1;
        if (!func_reg)
        begin
            if (!ovf_reg)
            begin
                if (no_room)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    if (!dead_now)
                    begin
                        ins_cur_next = new_cur;
                    end
                    if (alloc)
                    begin
                        free_next = free_reg + FREE_W'(1);
                    end
                    if (last_reg)
                    begin
                        ins_cur_next = '0;
                        dead_next    = 1'b0;
                    end
                    else
                    begin
                        dead_next = dead_now;
                    end
                end
            end
        end
        else
        begin
            if (sym_reg == SPACE_CHAR)
            begin
                match_cur_next = '0;
                mode_next      = MODE_MATCH;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_MATCH:
                    begin
                        if (mark_rd_reg)
                        begin
                            kept_next = 1'b0;
                            mode_next = MODE_DROP;
                        end
                        else if (!slot_ok_reg || (child_rd_reg == '0))
                        begin
                            mode_next = MODE_COPY;
                        end
                        else
                        begin
                            match_cur_next = child_rd_reg;
                        end
                    end
                    MODE_DROP:
                    begin
                        kept_next = 1'b0;
                    end
                    default:
                    begin
                        kept_next = 1'b1;
                    end
                endcase
            end
            if (last_reg)
            begin
                match_cur_next = '0;
                mode_next      = MODE_MATCH;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            child_mem[clear_cnt_reg] <= '0;
        end
        else if (child_we)
        begin
            child_mem[caddr_reg] <= free_reg[NODE_W-1:0];
        end
        if (cmd.load)
        begin
            child_rd_reg <= child_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear && (clear_cnt_reg < CADDR_W'(NODES)))
        begin
            mark_mem[clear_cnt_reg[NODE_W-1:0]] <= 1'b0;
        end
        else if (mark_we)
        begin
            mark_mem[new_cur] <= 1'b1;
        end
        if (cmd.load)
        begin
            mark_rd_reg <= mark_mem[rd_node];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            sym_reg     <= symbol;
            last_reg    <= last_symbol;
            slot_ok_reg <= in_slot_ok;
            caddr_reg   <= rd_addr;
        end
        if (commit && has_result)
        begin
            out_sym_reg <= sym_reg;
            kept_reg    <= kept_next;
            end_reg     <= last_reg;
            full_reg    <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            ins_cur_reg   <= '0;
            match_cur_reg <= '0;
            mode_reg      <= MODE_MATCH;
            free_reg      <= FREE_W'(1);
            ovf_reg       <= 1'b0;
            dead_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear && !sts.clear_done)
            begin
                clear_cnt_reg <= clear_cnt_reg + CADDR_W'(1);
            end
            if (commit)
            begin
                ins_cur_reg   <= ins_cur_next;
                match_cur_reg <= match_cur_next;
                mode_reg      <= mode_next;
                free_reg      <= free_next;
                ovf_reg       <= ovf_next;
                dead_reg      <= dead_next;
            end
            if (commit && has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_symbol   = out_sym_reg;
    assign kept         = kept_reg;
    assign sentence_end = end_reg;
    assign table_full   = full_reg;

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_W'(NODES))
        else $error("free node count beyond table");

    a_ins_cur_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        FREE_W'(ins_cur_reg) < free_reg)
        else $error("insert cursor on unallocated node");

    a_match_cur_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        FREE_W'(match_cur_reg) < free_reg)
        else $error("match cursor on unallocated node");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |=> ovf_reg)
        else $error("overflow flag cleared");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !out_valid_reg && !cmd.load)
        else $error("activity during clearing pass");

endmodule

/* hdl/trie_root_prefix_replacer.sv */
// Trie root prefix replacer: each request is handled in an accept step, then an execute step;
// a sentence result enters the output register when its execute step commits.
// A new request is accepted only after the previous execute step, set by the child table read followed
// by the decide and write step; a full output register holds the execute step.
// After reset a clearing pass sweeps all 26624 child table entries before
// the first request is accepted.
module trie_root_prefix_replacer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] symbol,
    input  logic       last_symbol,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_symbol,
    output logic       kept,
    output logic       sentence_end,
    output logic       table_full
);
    import trp_pkg::*;

    cmd_t    cmd;
    status_t sts;

    trp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    trp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .func         (func),
        .symbol       (symbol),
        .last_symbol  (last_symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_symbol   (out_symbol),
        .kept         (kept),
        .sentence_end (sentence_end),
        .table_full   (table_full)
    );

endmodule

/* tb/trie_root_prefix_replacer_test.sv */
// Self-checking testbench for trie_root_prefix_replacer: directed rows, then random
// dictionary and sentence requests under random idling, checked against a trie predictor.
// Depends on trp_pkg and the trie_root_prefix_replacer RTL.
module trie_root_prefix_replacer_test;
    import trp_pkg::*;

    localparam logic REQ_INSERT   = 1'b0;
    localparam logic REQ_SENTENCE = 1'b1;
    localparam logic BY_MODEL     = 1'b0;
    localparam logic BY_TABLE     = 1'b1;
    localparam int DIRECTED_ROWS  = 25;
    localparam int RANDOM_ITEMS   = 800;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_ROOTS      = 64;
    localparam int EXP_DEPTH      = 256;

    typedef struct packed {
        logic [7:0] sym;
        logic       kept;
        logic       send;
        logic       full;
    } result_t;

    typedef struct packed {
        logic       f;
        logic [7:0] sym;
        logic       last;
        logic       fixed;
        logic       kept;
        logic       full;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       func = 1'b0;
    logic [7:0] symbol = 8'h00;
    logic       last_symbol = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_symbol;
    logic       kept;
    logic       sentence_end;
    logic       table_full;

    bit [NODE_W-1:0] kid_node [ENTRIES];
    bit              root_mark [NODES];
    bit [FREE_W-1:0] free_node = FREE_W'(1);
    bit [NODE_W-1:0] ins_cur = '0;
    bit [NODE_W-1:0] walk_cur = '0;
    logic [1:0]      walk_mode = MODE_MATCH;
    bit              trie_full = 1'b0;
    bit              ins_dead = 1'b0;

    result_t  exp_fifo [EXP_DEPTH];
    int       exp_wr_cnt = 0;
    int       exp_rd_cnt = 0;
    result_t  rx_want;
    dir_row_t dir_rows [DIRECTED_ROWS];
    bit [7:0] root_txt [MAX_ROOTS][8];
    int       root_len [MAX_ROOTS];
    int       root_cnt = 0;
    int       burst_left = 0;
    int       items_sent = 0;
    int       err_cnt = 0;
    int       cycle_cnt = 0;
    int       rx_cnt = 0;
    logic [7:0] ready_pat = 8'h01;

    trie_root_prefix_replacer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .symbol       (symbol),
        .last_symbol  (last_symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_symbol   (out_symbol),
        .kept         (kept),
        .sentence_end (sentence_end),
        .table_full   (table_full)
    );

    always #6 clk = ~clk;

    function automatic bit [CADDR_W-1:0] slot_addr(input bit [NODE_W-1:0] n,
                                                   input logic [7:0] o);
        return CADDR_W'(n) * CADDR_W'(ALPHABET) + CADDR_W'(o);
    endfunction

    function automatic bit trie_step(input logic f, input logic [7:0] s, input logic l,
                                     output result_t r);
        bit              slot_ok;
        logic [7:0]      off;
        bit [CADDR_W-1:0] a;
        logic            k;
        k = 1'b1;
        r = '0;
        off = s - FIRST_LETTER;
        slot_ok = (s >= FIRST_LETTER) && (off < 8'(ALPHABET));
        if (f == REQ_INSERT)
        begin
            if (trie_full)
                return 1'b0;
            if (!slot_ok)
                ins_dead = 1'b1;
            if (!ins_dead)
            begin
                a = slot_addr(ins_cur, off);
                if (kid_node[a] == '0)
                begin
                    if (free_node >= FREE_W'(NODES))
                    begin
                        trie_full = 1'b1;
                        return 1'b0;
                    end
                    kid_node[a] = free_node[NODE_W-1:0];
                    free_node = free_node + FREE_W'(1);
                end
                ins_cur = kid_node[a];
            end
            if (l)
            begin
                if (!ins_dead)
                    root_mark[ins_cur] = 1'b1;
                ins_cur = '0;
                ins_dead = 1'b0;
            end
            return 1'b0;
        end
        if (s == SPACE_CHAR)
        begin
            walk_cur = '0;
            walk_mode = MODE_MATCH;
        end
        else if (walk_mode == MODE_MATCH)
        begin
            a = slot_addr(walk_cur, off);
            if (root_mark[walk_cur])
            begin
                k = 1'b0;
                walk_mode = MODE_DROP;
            end
            else if (!slot_ok || kid_node[a] == '0)
                walk_mode = MODE_COPY;
            else
                walk_cur = kid_node[a];
        end
        else if (walk_mode == MODE_DROP)
            k = 1'b0;
        if (l)
        begin
            walk_cur = '0;
            walk_mode = MODE_MATCH;
        end
        r.sym = s;
        r.kept = k;
        r.send = l;
        r.full = trie_full;
        return 1'b1;
    endfunction

    task automatic send_req(input logic f, input logic [7:0] s, input logic l,
                            input logic fixed, input logic tk, input logic tf);
        result_t r;
        bit has;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        func        <= f;
        symbol      <= s;
        last_symbol <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        items_sent++;
        has = trie_step(f, s, l, r);
        if (has)
        begin
            if (fixed == BY_TABLE)
            begin
                r.kept = tk;
                r.full = tf;
            end
            exp_fifo[8'(exp_wr_cnt)] = r;
            exp_wr_cnt++;
        end
    endtask

    task automatic send_dict_word(input int span, input int min_len, input int max_len,
                                  input bit noisy);
        int len;
        int pick;
        bit clean;
        logic [7:0] ch;
        bit [7:0] word [8];
        len = $urandom_range(min_len, max_len);
        clean = 1'b1;
        for (int i = 0; i < len; i++)
        begin
            ch = FIRST_LETTER + 8'($urandom_range(0, span - 1));
            if (noisy && $urandom_range(0, 15) == 0)
                ch = 8'($urandom_range(0, 255));
            if (ch < FIRST_LETTER || ch >= FIRST_LETTER + ALPHABET)
                clean = 1'b0;
            word[i] = ch;
            send_req(REQ_INSERT, ch, i == len - 1, BY_MODEL, 1'b0, 1'b0);
        end
        if (clean && len <= 8)
        begin
            pick = (root_cnt < MAX_ROOTS) ? root_cnt : $urandom_range(0, MAX_ROOTS - 1);
            root_txt[pick] = word;
            root_len[pick] = len;
            if (root_cnt < MAX_ROOTS)
                root_cnt++;
        end
    endtask

    task automatic send_sentence();
        bit [7:0] line_chars [64];
        int n;
        int nwords;
        int r;
        int wl;
        logic [7:0] ch;
        n = 0;
        nwords = $urandom_range(1, 4);
        for (int w = 0; w < nwords; w++)
        begin
            if (root_cnt > 0 && $urandom_range(0, 9) < 6)
            begin
                r = $urandom_range(0, root_cnt - 1);
                wl = root_len[r];
                if (wl > 1 && $urandom_range(0, 3) == 0)
                    wl--;
                for (int i = 0; i < wl; i++)
                    line_chars[n++] = root_txt[r][i];
                repeat ($urandom_range(0, 3))
                    line_chars[n++] = FIRST_LETTER + 8'($urandom_range(0, 5));
            end
            else
            begin
                repeat ($urandom_range(1, 5))
                    line_chars[n++] = FIRST_LETTER + 8'($urandom_range(0, 5));
            end
            if (w < nwords - 1 || $urandom_range(0, 7) == 0)
            begin
                line_chars[n++] = SPACE_CHAR;
                if ($urandom_range(0, 7) == 0)
                    line_chars[n++] = SPACE_CHAR;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            ch = line_chars[i];
            if ($urandom_range(0, 19) == 0)
                ch = 8'($urandom_range(0, 255));
            send_req(REQ_SENTENCE, ch, i == n - 1, BY_MODEL, 1'b0, 1'b0);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycle_cnt);
        err_cnt++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_rd_cnt == exp_wr_cnt)
                report_mismatch("unexpected result", out_symbol, 8'h00);
            else
            begin
                rx_want = exp_fifo[8'(exp_rd_cnt)];
                exp_rd_cnt++;
                if (out_symbol !== rx_want.sym)
                    report_mismatch("out_symbol", out_symbol, rx_want.sym);
                if (kept !== rx_want.kept)
                    report_mismatch("kept", {7'b0, kept}, {7'b0, rx_want.kept});
                if (sentence_end !== rx_want.send)
                    report_mismatch("sentence_end", {7'b0, sentence_end},
                                    {7'b0, rx_want.send});
                if (table_full !== rx_want.full)
                    report_mismatch("table_full", {7'b0, table_full}, {7'b0, rx_want.full});
            end
        end
        rx_cnt <= rx_cnt + 1;
        if (rx_cnt % 96 == 0)
            ready_pat <= 8'($urandom) | 8'h01;
        else
            ready_pat <= {ready_pat[6:0], ready_pat[7]};
        out_ready <= (rx_cnt[10:9] == 2'b00) ? 1'b1 : ready_pat[0];
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL trie_root_prefix_replacer");
        $finish;
    end

    initial
    begin
        dir_rows = '{
            '{REQ_SENTENCE, "a",   1'b1, BY_TABLE, 1'b1, 1'b0},
            '{REQ_SENTENCE, 8'h00, 1'b0, BY_TABLE, 1'b1, 1'b0},
            '{REQ_SENTENCE, 8'hff, 1'b1, BY_TABLE, 1'b1, 1'b0},
            '{REQ_INSERT,   "a",   1'b0, BY_MODEL, 1'b0, 1'b0},
            '{REQ_INSERT,   "b",   1'b1, BY_MODEL, 1'b0, 1'b0},
            '{REQ_INSERT,   "z",   1'b1, BY_MODEL, 1'b0, 1'b0},
            '{REQ_INSERT,   "x",   1'b0, BY_MODEL, 1'b0, 1'b0},
            '{REQ_INSERT,   "{",   1'b0, BY_MODEL, 1'b0, 1'b0},
            '{REQ_INSERT,   "y",   1'b1, BY_MODEL, 1'b0, 1'b0},
            '{REQ_INSERT,   8'h60, 1'b1, BY_MODEL, 1'b0, 1'b0},
            '{REQ_SENTENCE, "a",   1'b0, BY_TABLE, 1'b1, 1'b0},
            '{REQ_SENTENCE, "b",   1'b0, BY_TABLE, 1'b1, 1'b0},
            '{REQ_SENTENCE, "c",   1'b0, BY_TABLE, 1'b0, 1'b0},
            '{REQ_SENTENCE, "d",   1'b0, BY_TABLE, 1'b0, 1'b0},
            '{REQ_SENTENCE, " ",   1'b0, BY_TABLE, 1'b1, 1'b0},
            '{REQ_SENTENCE, "z",   1'b0, BY_TABLE, 1'b1, 1'b0},
            '{REQ_SENTENCE, "z",   1'b0, BY_TABLE, 1'b0, 1'b0},
            '{REQ_SENTENCE, " ",   1'b0, BY_TABLE, 1'b1, 1'b0},
            '{REQ_SENTENCE, "x",   1'b0, BY_TABLE, 1'b1, 1'b0},
            '{REQ_SENTENCE, "y",   1'b0, BY_MODEL, 1'b0, 1'b0},
            '{REQ_SENTENCE, " ",   1'b0, BY_MODEL, 1'b0, 1'b0},
            '{REQ_SENTENCE, "a",   1'b0, BY_MODEL, 1'b0, 1'b0},
            '{REQ_SENTENCE, "b",   1'b0, BY_MODEL, 1'b0, 1'b0},
            '{REQ_SENTENCE, "q",   1'b1, BY_TABLE, 1'b0, 1'b0},
            '{REQ_SENTENCE, " ",   1'b1, BY_MODEL, 1'b0, 1'b0}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_req(dir_rows[i].f, dir_rows[i].sym, dir_rows[i].last,
                     dir_rows[i].fixed, dir_rows[i].kept, dir_rows[i].full);
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 3)
                send_dict_word(6, 1, 4, 1'b1);
            else
                send_sentence();
        end
        repeat (4) send_sentence();
        in_valid <= 1'b0;
        while (exp_rd_cnt != exp_wr_cnt)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS trie_root_prefix_replacer");
        else
            $display("FAIL trie_root_prefix_replacer");
        $finish;
    end

endmodule
